### sv/amdc_pkg.sv
// amdc_pkg: shared types and constants for the adjacency matrix dominating check
// operation codes, register indexes, sequencer states and the result bundle
// no dependencies
`timescale 1ns / 1ps

package amdc_pkg;

  // operation codes carried in a request
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // configuration register indexes
  localparam logic REG_NODE_COUNT    = 1'b0;
  localparam logic REG_DIRECTED_MODE = 1'b1;

  // width of an active node count, holds the 6-bit register and up to 64
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_TEST_A,
    ST_READ_B,
    ST_TEST_B,
    ST_CHECK,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       edge_present;
    logic       dominating;
    logic [4:0] uncovered_node;
    logic       bad_node;
  } result_t;

endpackage

### sv/amdc_mem.sv
// amdc_mem: adjacency row memory, one write port and one registered read port
// per-row valid bits make unwritten rows read as zero after reset
// depends on nothing
`timescale 1ns / 1ps

module amdc_mem #(
  parameter int MAX_NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic [MAX_NODES-1:0]         rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [MAX_NODES-1:0]         wr_data
);

  logic [MAX_NODES-1:0] rows [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? rows[rd_addr] : '0;
    end
  end

endmodule

### sv/amdc_alu.sv
// amdc_alu: shared row unit, tests a row against an operand vector and
// produces the row with the operand bits set or cleared
// depends on nothing
`timescale 1ns / 1ps

module amdc_alu #(
  parameter int MAX_NODES = 32
) (
  input  logic [MAX_NODES-1:0] row,
  input  logic [MAX_NODES-1:0] operand,
  input  logic                 set_bits,
  output logic                 hit,
  output logic [MAX_NODES-1:0] row_upd
);

  assign hit     = |(row & operand);
  assign row_upd = set_bits ? (row | operand) : (row & ~operand);

endmodule

### sv/amdc_seq.sv
// amdc_seq: sequencer that runs one request at a time over the row memory
// and the shared row unit, and holds the result until the output takes it
// depends on amdc_pkg
`timescale 1ns / 1ps

module amdc_seq
  import amdc_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [4:0]                   from_node,
  input  logic [4:0]                   to_node,
  input  logic [31:0]                  group_mask,
  input  logic [COUNT_W-1:0]           active,
  input  logic                         directed_mode,
  output logic                         rd_en,
  output logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic [MAX_NODES-1:0]         rd_data,
  output logic                         wr_en,
  output logic [$clog2(MAX_NODES)-1:0] wr_addr,
  output logic [MAX_NODES-1:0]         wr_data,
  output logic [MAX_NODES-1:0]         alu_operand,
  output logic                         alu_set,
  input  logic                         alu_hit,
  input  logic [MAX_NODES-1:0]         alu_row_upd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output result_t                      res
);

  localparam int RW = $clog2(MAX_NODES);

  seq_state_t           state, state_next;
  logic [1:0]           op_q;
  logic [RW-1:0]        a_q, b_q;
  logic [MAX_NODES-1:0] grp_q;
  logic [COUNT_W-1:0]   cnt;
  logic                 pend;
  logic [RW-1:0]        pend_row;

  logic                 bad_in;
  logic [MAX_NODES-1:0] grp_in;
  logic                 fail;
  logic                 issue;
  logic                 accept;

  assign accept = (state == ST_IDLE) && in_valid;

  assign bad_in = ({2'b00, from_node} >= active) || ({2'b00, to_node} >= active);

  // mask limited to nodes below the active count
  always_comb begin
    grp_in = MAX_NODES'(group_mask);
    for (int k = 0; k < MAX_NODES; k++) begin
      if (COUNT_W'(k) >= active) begin
        grp_in[k] = 1'b0;
      end
    end
  end

  assign fail  = (state == ST_CHECK) && pend && !grp_q[pend_row] && !alu_hit;
  assign issue = (state == ST_CHECK) && (cnt < active) && !fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_CHECK) begin
            state_next = (grp_in == '0) ? ST_DONE : ST_CHECK;
          end else if (bad_in) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ_A;
          end
        end
      end
      ST_READ_A: state_next = ST_TEST_A;
      ST_TEST_A: begin
        if (op_q == OP_QUERY || directed_mode) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ_B;
        end
      end
      ST_READ_B: state_next = ST_TEST_B;
      ST_TEST_B: state_next = ST_DONE;
      ST_CHECK: begin
        if (fail || cnt >= active) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = a_q;
    wr_en       = 1'b0;
    wr_addr     = a_q;
    alu_operand = MAX_NODES'(1) << b_q;
    alu_set     = (op_q == OP_ADD);
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ_A: rd_en = 1'b1;
      ST_TEST_A: wr_en = (op_q != OP_QUERY);
      ST_READ_B: begin
        rd_en   = 1'b1;
        rd_addr = b_q;
      end
      ST_TEST_B: begin
        wr_en       = 1'b1;
        wr_addr     = b_q;
        alu_operand = MAX_NODES'(1) << a_q;
      end
      ST_CHECK: begin
        rd_en       = issue;
        rd_addr     = RW'(cnt);
        alu_operand = grp_q;
      end
      ST_DONE:   res_valid = 1'b1;
      default: ;
    endcase
  end

  assign wr_data = alu_row_upd;

  // pending flag marks a row read in flight during a group check
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b0;
    end else if (state == ST_CHECK) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q               <= operation;
      a_q                <= RW'(from_node);
      b_q                <= RW'(to_node);
      grp_q              <= grp_in;
      cnt                <= '0;
      res.edge_present   <= 1'b0;
      res.dominating     <= (operation == OP_CHECK);
      res.uncovered_node <= '0;
      res.bad_node       <= (operation != OP_CHECK) && bad_in;
    end else begin
      if (state == ST_TEST_A && op_q == OP_QUERY) begin
        res.edge_present <= alu_hit;
      end
      if (issue) begin
        cnt      <= cnt + 1'b1;
        pend_row <= RW'(cnt);
      end
      if (fail) begin
        res.dominating     <= 1'b0;
        res.uncovered_node <= 5'(pend_row);
      end
    end
  end

endmodule

### sv/adjacency_matrix_dominating_check.sv
// adjacency_matrix_dominating_check: top level with configuration registers,
// output register, row memory, shared row unit and sequencer
// depends on amdc_pkg, amdc_mem, amdc_alu, amdc_seq
//
// usage
//   request channel: in_valid / in_stall with operation, from_node, to_node and
//   group_mask; one request is taken at a time, in_stall stays high while the
//   sequencer works on the current one
//   result channel: out_valid / out_stall with edge_present, dominating,
//   uncovered_node and bad_node; every request gives exactly one result
//   steps: a bad node or empty group goes straight to the result, a query
//   reads and tests one row, a directed add/erase makes one read-modify-write
//   pass, an undirected add/erase two, and a group check streams up to
//   active_count matrix rows, one per cycle, through the single memory read port
//   the sequencer passes through idle between requests, so a new request is
//   not taken until the current result has left the sequencer
//   the result sits in an output register; a new request is taken while it
//   waits, and the sequencer holds the next result until the register frees
//   reset (synchronous) empties the matrix through per-row valid bits, sets
//   node_count to 32 and directed_mode to 0; there is no clearing pass
//   configuration writes are taken at any cycle with cfg_write_enable high
`timescale 1ns / 1ps

module adjacency_matrix_dominating_check
  import amdc_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [4:0]  from_node,
  input  logic [4:0]  to_node,
  input  logic [31:0] group_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        edge_present,
  output logic        dominating,
  output logic [4:0]  uncovered_node,
  output logic        bad_node
);

  localparam int RW = $clog2(MAX_NODES);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_NODES);

  // configuration registers
  logic [5:0]         node_count;
  logic               directed_mode;
  logic [COUNT_W-1:0] active;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= 6'd32;
      directed_mode <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_NODE_COUNT:    node_count    <= cfg_data;
        REG_DIRECTED_MODE: directed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // node count saturated to the built matrix size
  assign active = ({1'b0, node_count} > MAX_COUNT) ? MAX_COUNT : {1'b0, node_count};

  // memory and shared unit wiring
  logic                 rd_en, wr_en;
  logic [RW-1:0]        rd_addr, wr_addr;
  logic [MAX_NODES-1:0] rd_data, wr_data;
  logic [MAX_NODES-1:0] alu_operand, alu_row_upd;
  logic                 alu_set, alu_hit;
  logic                 in_ready;
  logic                 res_valid;
  logic                 out_free;
  result_t              res;

  amdc_mem #(.MAX_NODES(MAX_NODES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  amdc_alu #(.MAX_NODES(MAX_NODES)) u_alu (
    .row      (rd_data),
    .operand  (alu_operand),
    .set_bits (alu_set),
    .hit      (alu_hit),
    .row_upd  (alu_row_upd)
  );

  amdc_seq #(.MAX_NODES(MAX_NODES)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .from_node     (from_node),
    .to_node       (to_node),
    .group_mask    (group_mask),
    .active        (active),
    .directed_mode (directed_mode),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .alu_operand   (alu_operand),
    .alu_set       (alu_set),
    .alu_hit       (alu_hit),
    .alu_row_upd   (alu_row_upd),
    .res_valid     (res_valid),
    .res_ready     (out_free),
    .res           (res)
  );

  assign in_stall = !in_ready;

  // output register, frees when empty or when the receiver takes it
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      edge_present   <= res.edge_present;
      dominating     <= res.dominating;
      uncovered_node <= res.uncovered_node;
      bad_node       <= res.bad_node;
    end
  end

endmodule
